// ===== design/trs_pkg.sv =====
// shared widths, codes and window-length helper for the traffic rate statistics block
package trs_pkg;

   // field widths
   localparam int MODE_W  = 1;
   localparam int RATE_W  = 32;
   localparam int TOTAL_W = 63;
   localparam int STEPS_W = 4;

   // default sizes of the history ring
   localparam int HISTORY_DEPTH_DEF    = 512;
   localparam int SAMPLES_PER_STEP_DEF = 45;
   localparam int MAX_STEPS            = 9;

   // reset value of the window register
   localparam logic [STEPS_W-1:0] RESET_STEPS = 4'd3;

   // transaction mode codes
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 1'b0;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 1'b1;

   // wrap step of the kernel byte counter and total ceiling
   localparam logic [RATE_W-1:0]  WRAP_MOD  = 32'hFFFF_FFFF;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // window length in samples from the steps register
   function automatic int win_len_calc(input logic [STEPS_W-1:0] steps, input int sps,
                                       input int depth);
      int s;
      int len;
      s = int'(steps);
      if (s < 1) s = 1;
      if (s > MAX_STEPS) s = MAX_STEPS;
      len = s * sps;
      if (len > depth) len = depth;
      if (len < 1) len = 1;
      return len;
   endfunction

endpackage

// ===== design/trs_ifs.sv =====
// channel interfaces: sample requests, statistics responses and window register writes

interface trs_req_if;
   logic                        valid;
   logic                        ready;
   logic [trs_pkg::MODE_W-1:0]  mode;
   logic [trs_pkg::RATE_W-1:0]  rate_sample;
   logic [trs_pkg::TOTAL_W-1:0] raw_total;
   modport source (output valid, mode, rate_sample, raw_total, input ready);
   modport sink   (input valid, mode, rate_sample, raw_total, output ready);
endinterface

interface trs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [trs_pkg::RATE_W-1:0]  current_rate;
   logic [trs_pkg::RATE_W-1:0]  minimum_rate;
   logic [trs_pkg::RATE_W-1:0]  maximum_rate;
   logic [trs_pkg::RATE_W-1:0]  average_rate;
   logic [trs_pkg::TOTAL_W-1:0] extended_total;
   modport source (output valid, current_rate, minimum_rate, maximum_rate, average_rate,
                   extended_total, input ready);
   modport sink   (input valid, current_rate, minimum_rate, maximum_rate, average_rate,
                   extended_total, output ready);
endinterface

interface trs_csr_if;
   logic                        valid;
   logic                        ready;
   logic [trs_pkg::STEPS_W-1:0] window_steps;
   modport source (output valid, window_steps, input ready);
   modport sink   (input valid, window_steps, output ready);
endinterface

// ===== design/trs_ram.sv =====
// generic single-write, single-read ram with registered read data
module trs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/trs_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module trs_div #(
   parameter int DIVIDEND_W = 42,
   parameter int DIVISOR_W  = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int ITER_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff,  busy_in;
   logic                  done_ff,  done_in;
   logic [ITER_W-1:0]     iter_ff,  iter_in;
   logic [DIVISOR_W-1:0]  rem_ff,   rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff,   dvs_in;
   logic [DIVIDEND_W-1:0] quo_ff,   quo_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // one shift-compare-subtract step, or a load of the operands on start
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits    = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = ITER_W'(DIVIDEND_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : DIVISOR_W'(trial);
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         iter_in = iter_ff - ITER_W'(1);
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/traffic_rate_statistics_unit.sv =====
// traffic rate statistics: current, min, max, windowed average rate and wrap-extended byte total
// a sample response passes S_READ, S_WRITE, S_EXT1, S_EXT2, S_DIV and S_OUT before it is valid;
// S_DIV waits for the bit-serial divider for the average, one bit per cycle
// a clear response goes from S_IDLE straight to S_OUT; the next transaction is taken from
// the cycle after a response is loaded, later only while the previous response still waits
// synchronous reset clears all statistics and loads the window register with 3 steps
module traffic_rate_statistics_unit #(
   parameter int HISTORY_DEPTH    = trs_pkg::HISTORY_DEPTH_DEF,
   parameter int SAMPLES_PER_STEP = trs_pkg::SAMPLES_PER_STEP_DEF
) (
   input  logic      clock,
   input  logic      reset,
   trs_req_if.sink   req_bus,
   trs_rsp_if.source rsp_bus,
   trs_csr_if.sink   csr_bus
);

   import trs_pkg::*;

   localparam int PTR_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W = RATE_W + CNT_W;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_WRITE, S_EXT1, S_EXT2, S_DIV, S_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [STEPS_W-1:0]   steps_ff, steps_in;
   logic [CNT_W-1:0]     win_len_ff, win_len_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [RATE_W-1:0]    latest_ff, latest_in;
   logic [RATE_W-1:0]    low_ff, low_in;
   logic [RATE_W-1:0]    high_ff, high_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [RATE_W-1:0]    avg_ff, avg_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic [TOTAL_W-1:0]   raw_ff, raw_in;
   logic [RATE_W-1:0]    quo_ff, quo_in;
   logic [RATE_W-1:0]    rem_ff, rem_in;
   logic [RATE_W+32:0]   base_ff, base_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]    out_cur_ff, out_cur_in;
   logic [RATE_W-1:0]    out_min_ff, out_min_in;
   logic [RATE_W-1:0]    out_max_ff, out_max_in;
   logic [RATE_W-1:0]    out_avg_ff, out_avg_in;
   logic [TOTAL_W-1:0]   out_tot_ff, out_tot_in;

   logic                 req_take;
   logic                 ram_wr_en;
   logic [RATE_W-1:0]    ram_rd_data;
   logic                 div_start;
   logic                 div_done;
   logic [SUM_W-1:0]     div_quo;
   logic [PTR_W:0]       ptr_inc;
   logic [RATE_W:0]      fold_sum;
   logic [RATE_W:0]      q_adj;
   logic [RATE_W+34:0]   ext_sum;
   logic [RATE_W+34:0]   ext_t;

   // rate history ring
   trs_ram #(
      .WIDTH (RATE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (rate_ff),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   // divider for the window average
   trs_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      steps_in     = steps_ff;
      win_len_in   = win_len_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      latest_in    = latest_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      total_in     = total_ff;
      avg_in       = avg_ff;
      rate_in      = rate_ff;
      raw_in       = raw_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      out_cur_in   = out_cur_ff;
      out_min_in   = out_min_ff;
      out_max_in   = out_max_ff;
      out_avg_in   = out_avg_ff;
      out_tot_in   = out_tot_ff;
      ram_wr_en    = 1'b0;
      div_start    = 1'b0;
      ptr_inc      = {1'b0, ptr_ff} + (PTR_W + 1)'(1);
      fold_sum     = (RATE_W + 1)'(total_ff[TOTAL_W-1:RATE_W]) +
                     (RATE_W + 1)'(total_ff[RATE_W-1:0]);
      q_adj        = (RATE_W + 1)'(quo_ff) + (RATE_W + 1)'(raw_ff < TOTAL_W'(rem_ff));
      ext_sum      = (RATE_W + 35)'(base_ff) + (RATE_W + 35)'(raw_ff);
      ext_t        = (raw_ff >= TOTAL_W'(WRAP_MOD)) ? (RATE_W + 35)'(raw_ff) : ext_sum;

      // window register writes
      if (csr_bus.valid) begin
         steps_in = csr_bus.window_steps;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               rate_in = req_bus.rate_sample;
               raw_in  = req_bus.raw_total;
               if (req_bus.mode == MODE_CLEAR) begin
                  win_len_in = CNT_W'(win_len_calc(steps_ff, SAMPLES_PER_STEP, HISTORY_DEPTH));
                  ptr_in     = '0;
                  count_in   = '0;
                  sum_in     = '0;
                  latest_in  = '0;
                  low_in     = '0;
                  high_in    = '0;
                  total_in   = '0;
                  avg_in     = '0;
                  state_in   = S_OUT;
               end else begin
                  latest_in = req_bus.rate_sample;
                  if (low_ff == '0 && high_ff == '0) begin
                     low_in  = req_bus.rate_sample;
                     high_in = req_bus.rate_sample;
                  end else begin
                     if (req_bus.rate_sample < low_ff) low_in = req_bus.rate_sample;
                     if (req_bus.rate_sample > high_ff) high_in = req_bus.rate_sample;
                  end
                  state_in = S_READ;
               end
            end
         end
         // drop the oldest rate once the window is full, else count the new one
         S_READ: begin
            if (count_ff >= win_len_ff) begin
               sum_in = sum_ff - SUM_W'(ram_rd_data);
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
            state_in = S_WRITE;
         end
         // store and sum the new rate, advance the ring, split the old total by the wrap step
         S_WRITE: begin
            ram_wr_en = 1'b1;
            sum_in    = sum_ff + SUM_W'(rate_ff);
            if (CNT_W'(ptr_inc) >= win_len_ff) begin
               ptr_in = '0;
            end else begin
               ptr_in = ptr_inc[PTR_W-1:0];
            end
            if (fold_sum >= (RATE_W + 1)'(WRAP_MOD)) begin
               quo_in = RATE_W'(total_ff[TOTAL_W-1:RATE_W]) + RATE_W'(1);
               rem_in = RATE_W'(fold_sum - (RATE_W + 1)'(WRAP_MOD));
            end else begin
               quo_in = RATE_W'(total_ff[TOTAL_W-1:RATE_W]);
               rem_in = fold_sum[RATE_W-1:0];
            end
            state_in = S_EXT1;
         end
         // base of the wrap-corrected total
         S_EXT1: begin
            base_in  = {q_adj, 32'h0} - (RATE_W + 33)'(q_adj);
            state_in = S_EXT2;
         end
         // add the raw total and saturate, then start the divider
         S_EXT2: begin
            if (ext_t[RATE_W+34:TOTAL_W] != '0) begin
               total_in = TOTAL_MAX;
            end else begin
               total_in = ext_t[TOTAL_W-1:0];
            end
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               avg_in   = div_quo[RATE_W-1:0];
               state_in = S_OUT;
            end
         end
         // load the response register when it is free
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               out_cur_in   = latest_ff;
               out_min_in   = low_ff;
               out_max_in   = high_ff;
               out_avg_in   = avg_ff;
               out_tot_in   = total_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         steps_ff     <= RESET_STEPS;
         win_len_ff   <= CNT_W'(win_len_calc(RESET_STEPS, SAMPLES_PER_STEP, HISTORY_DEPTH));
         ptr_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         latest_ff    <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         total_ff     <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         steps_ff     <= steps_in;
         win_len_ff   <= win_len_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         latest_ff    <= latest_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         total_ff     <= total_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rate_ff    <= rate_in;
      raw_ff     <= raw_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      base_ff    <= base_in;
      out_cur_ff <= out_cur_in;
      out_min_ff <= out_min_in;
      out_max_ff <= out_max_in;
      out_avg_ff <= out_avg_in;
      out_tot_ff <= out_tot_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.current_rate   = out_cur_ff;
   assign rsp_bus.minimum_rate   = out_min_ff;
   assign rsp_bus.maximum_rate   = out_max_ff;
   assign rsp_bus.average_rate   = out_avg_ff;
   assign rsp_bus.extended_total = out_tot_ff;

endmodule
